FILE: rtl/core/hea_pkg.sv
`default_nettype none

package hea_pkg;

	// Geometry of one histogram word and of the float format.
	localparam int LANES        = 8;
	localparam int LANE_W       = $clog2(LANES);
	localparam int COUNT_W      = 25;
	localparam int FLOAT_W      = 32;
	localparam int POLY_DEGREE  = 6;
	localparam int COEF_IDX_W   = $clog2(POLY_DEGREE + 1);
	localparam int QUEUE_DEPTH  = 2;
	localparam int CFG_INDEX_W  = 1;
	localparam int DIV_STEPS    = 54;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_PIXELS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEGATE_SUM   = 1'b1;

	// Float constants.
	localparam logic [FLOAT_W-1:0] FLOAT_ONE = 32'h3f80_0000;
	localparam logic [FLOAT_W-1:0] MANT_MASK = 32'h007f_ffff;
	localparam logic [7:0]         EXP_BIAS  = 8'd127;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [FLOAT_W-1:0] float_t;

	// One queued histogram word with its classification.
	typedef struct packed {
		logic [LANES-1:0][COUNT_W-1:0] count;
		logic [LANES-1:0]              nonzero;
		logic                          last;
	} word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		FPU_MUL,
		FPU_ADD,
		FPU_CVT
	} fpu_op_t;

	// Request to the shared float unit; the convert takes a sign and magnitude.
	typedef struct packed {
		fpu_op_t op;
		float_t  a;
		float_t  b;
		logic    cvt_neg;
		count_t  cvt_mag;
	} fpu_req_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_LANE,
		BK_CVT,
		BK_SCALE,
		BK_HMUL,
		BK_HADD,
		BK_EXPCVT,
		BK_LOG,
		BK_PROD,
		BK_ACC,
		BK_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		RC_IDLE,
		RC_NORM,
		RC_DIV,
		RC_ROUND
	} recip_state_t;

	// Single-precision coefficients of the log2 mantissa polynomial, lowest order first.
	function automatic float_t poly_coef(input logic [COEF_IDX_W-1:0] idx);
		float_t c;
		case (idx)
			3'd0: c = 32'hc041_e921;
			3'd1: c = 32'h40c2_4b70;
			3'd2: c = 32'hc0a8_bef7;
			3'd3: c = 32'h404e_7cbf;
			3'd4: c = 32'hbf9e_6b92;
			3'd5: c = 32'h3e89_0a2f;
			3'd6: c = 32'hbccb_fe34;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hea_fpu.sv
`default_nettype none

module hea_fpu (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  hea_pkg::fpu_req_t req,
	output logic              done,
	output hea_pkg::float_t   result
);

	logic               v_s1, v_s2, done_q;
	logic [47:0]        m_s1;
	logic signed [9:0]  e_s1;
	logic               sg_s1;
	logic [47:0]        mn_s2;
	logic signed [9:0]  e_s2;
	logic               sg_s2, z_s2;
	hea_pkg::float_t    result_q;

	logic [47:0]        m1;
	logic signed [9:0]  e1;
	logic               s1;

	// Stage one: raw product, aligned sum or integer placement.
	always_comb begin
		logic [7:0]  ea, eb, ebig, esml, d;
		logic [23:0] ma, mb, mbig, msml;
		logic [47:0] aext, bext, sh;
		logic        a_big, sbig, lost;
		ea = req.a[30:23];
		eb = req.b[30:23];
		ma = {|ea, req.a[22:0]};
		mb = {|eb, req.b[22:0]};
		a_big = req.a[30:0] >= req.b[30:0];
		ebig = a_big ? ea : eb;
		esml = a_big ? eb : ea;
		mbig = a_big ? ma : mb;
		msml = a_big ? mb : ma;
		sbig = a_big ? req.a[31] : req.b[31];
		d = ebig - esml;
		aext = {1'b0, mbig, 23'b0};
		bext = {1'b0, msml, 23'b0};
		if (d >= 8'd48) begin
			sh = '0;
			lost = |bext;
		end else begin
			sh = bext >> d;
			lost = |(bext & ~({48{1'b1}} << d));
		end
		sh[0] = sh[0] | lost;
		m1 = '0;
		e1 = '0;
		s1 = 1'b0;
		case (req.op)
			hea_pkg::FPU_MUL: begin
				m1 = (ea == 8'd0 || eb == 8'd0) ? 48'd0 : ma * mb;
				e1 = $signed({2'b0, ea}) + $signed({2'b0, eb}) - 10'sd127;
				s1 = req.a[31] ^ req.b[31];
			end
			hea_pkg::FPU_ADD: begin
				m1 = (req.a[31] == req.b[31]) ? aext + sh : aext - sh;
				e1 = $signed({2'b0, ebig});
				s1 = (m1 == 48'd0) ? (req.a[31] & req.b[31]) : sbig;
			end
			hea_pkg::FPU_CVT: begin
				m1 = {{(48 - hea_pkg::COUNT_W){1'b0}}, req.cvt_mag};
				e1 = 10'sd173;
				s1 = req.cvt_neg;
			end
			default: begin
				m1 = '0;
			end
		endcase
	end

	// Stage two: leading one search and normalizing shift.
	logic [5:0] pos;
	always_comb begin
		pos = '0;
		for (int i = 0; i < 48; i++) begin
			if (m_s1[i]) pos = 6'(i);
		end
	end

	// Stage three: round to nearest even.
	logic [23:0] mant24;
	logic [24:0] sum25;
	logic        up;
	logic [7:0]  e_fin;
	always_comb begin
		mant24 = mn_s2[47:24];
		up = mn_s2[23] & ((|mn_s2[22:0]) | mant24[0]);
		sum25 = {1'b0, mant24} + {24'd0, up};
		e_fin = e_s2[7:0] + {7'd0, sum25[24]};
	end

	// Control of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			done_q <= v_s2;
		end
	end

	// Stage data.
	always_ff @(posedge clk) begin
		m_s1 <= m1;
		e_s1 <= e1;
		sg_s1 <= s1;
		mn_s2 <= m_s1 << (6'd47 - pos);
		e_s2 <= e_s1 + $signed({4'b0, pos}) - 10'sd46;
		sg_s2 <= sg_s1;
		z_s2 <= (m_s1 == 48'd0);
		if (z_s2) begin
			result_q <= {sg_s2, 31'd0};
		end else begin
			result_q <= {sg_s2, e_fin, sum25[24] ? 23'd0 : sum25[22:0]};
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: rtl/core/hea_recip.sv
`default_nettype none

module hea_recip (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  hea_pkg::count_t  total,
	output logic             busy,
	output hea_pkg::float_t  scale
);

	localparam int STEP_W = $clog2(hea_pkg::DIV_STEPS);

	hea_pkg::recip_state_t state_q, state_d;
	logic [hea_pkg::COUNT_W-1:0] tn_q;
	logic [4:0]                  sh_q;
	logic [hea_pkg::COUNT_W:0]   rem_q;
	logic [hea_pkg::DIV_STEPS-1:0] q_q;
	logic [STEP_W-1:0]           step_q;
	hea_pkg::float_t             scale_q;

	// Next state of the reciprocal sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			hea_pkg::RC_IDLE:  if (start) state_d = hea_pkg::RC_NORM;
			hea_pkg::RC_NORM:  if (tn_q[hea_pkg::COUNT_W-1]) state_d = hea_pkg::RC_DIV;
			hea_pkg::RC_DIV: begin
				if (step_q == STEP_W'(hea_pkg::DIV_STEPS - 1)) state_d = hea_pkg::RC_ROUND;
			end
			hea_pkg::RC_ROUND: state_d = hea_pkg::RC_IDLE;
			default:           state_d = hea_pkg::RC_IDLE;
		endcase
	end

	// One restoring division step.
	logic [hea_pkg::COUNT_W:0] r2;
	logic                      ge;
	always_comb begin
		r2 = {rem_q[hea_pkg::COUNT_W-1:0], 1'b0};
		ge = r2 >= {1'b0, tn_q};
	end

	// Round the quotient to double, then the double to single.
	logic [52:0] d53;
	logic [23:0] m24;
	logic        up1, up2;
	logic [7:0]  exp_fin;
	always_comb begin
		up1 = q_q[1] & (q_q[0] | (rem_q != '0) | q_q[2]);
		d53 = {1'b0, q_q[53:2]} + {52'd0, up1};
		up2 = d53[28] & ((|d53[27:0]) | d53[29]);
		m24 = {1'b0, d53[51:29]} + {23'd0, up2};
		exp_fin = 8'd102 + {3'b0, sh_q} + {7'd0, d53[52]} + {7'd0, m24[23]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hea_pkg::RC_IDLE;
			scale_q <= hea_pkg::FLOAT_ONE;
		end else begin
			state_q <= state_d;
			if (state_q == hea_pkg::RC_ROUND) scale_q <= {1'b0, exp_fin, m24[22:0]};
		end
	end

	// Working registers of the divider.
	always_ff @(posedge clk) begin
		case (state_q)
			hea_pkg::RC_IDLE: begin
				tn_q <= (total == '0) ? hea_pkg::COUNT_W'(1) : total;
				sh_q <= '0;
			end
			hea_pkg::RC_NORM: begin
				if (tn_q[hea_pkg::COUNT_W-1]) begin
					rem_q <= {1'b1, {hea_pkg::COUNT_W{1'b0}}} - {1'b0, tn_q};
					step_q <= '0;
				end else begin
					tn_q <= tn_q << 1;
					sh_q <= sh_q + 5'd1;
				end
			end
			hea_pkg::RC_DIV: begin
				rem_q <= ge ? r2 - {1'b0, tn_q} : r2;
				q_q <= {q_q[hea_pkg::DIV_STEPS-2:0], ge};
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != hea_pkg::RC_IDLE);
	assign scale = scale_q;

endmodule

`default_nettype wire

FILE: rtl/core/hea_front.sv
`default_nettype none

module hea_front (
	input  wire                                            clk,
	input  wire                                            arst_n,
	input  wire                                            item_valid,
	output logic                                           item_stall,
	input  wire [hea_pkg::LANES-1:0][hea_pkg::COUNT_W-1:0] counts,
	input  wire                                            last,
	input  wire                                            hold,
	input  wire                                            pop,
	output hea_pkg::word_t                                 head,
	output hea_pkg::queue_status_t                         status
);

	localparam int PTR_W  = (hea_pkg::QUEUE_DEPTH > 1) ? $clog2(hea_pkg::QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(hea_pkg::QUEUE_DEPTH + 1);

	hea_pkg::word_t    entry_q [hea_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push, full, empty;
	hea_pkg::word_t    word_in;

	// Classify the word: which lanes carry a count at all.
	always_comb begin
		word_in.count = counts;
		word_in.last = last;
		for (int i = 0; i < hea_pkg::LANES; i++) begin
			word_in.nonzero[i] = (counts[i] != '0);
		end
	end

	assign full = (fill_q == FILL_W'(hea_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign item_stall = full | hold;
	assign push = item_valid & ~item_stall;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(hea_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) fill_q <= fill_q + FILL_W'(1);
			else if (pop && !push) fill_q <= fill_q - FILL_W'(1);
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= word_in;
	end

	assign head = entry_q[rd_ptr_q];
	assign status.full = full;
	assign status.empty = empty;

endmodule

`default_nettype wire

FILE: rtl/core/hea_back.sv
`default_nettype none

module hea_back (
	input  wire                                            clk,
	input  wire                                            arst_n,
	input  hea_pkg::word_t                                 head,
	input  wire                                            head_valid,
	output logic                                           pop,
	input  hea_pkg::float_t                                scale,
	input  wire                                            negate,
	input  wire                                            result_stall,
	output logic                                           result_valid,
	output logic [hea_pkg::LANES-1:0][hea_pkg::FLOAT_W-1:0] result
);

	hea_pkg::back_state_t state_q, state_d;
	logic [hea_pkg::LANE_W-1:0]     lane_q;
	logic [hea_pkg::COEF_IDX_W-1:0] idx_q;
	logic                           busy_q;
	hea_pkg::float_t                work_q, tmp_q, p_q;
	hea_pkg::float_t                sum_q [hea_pkg::LANES];
	logic                           res_valid_q;
	logic [hea_pkg::LANES-1:0][hea_pkg::FLOAT_W-1:0] res_q;

	hea_pkg::fpu_req_t req;
	logic              start, done, op_state, lane_done, lane_last, emit;
	hea_pkg::float_t   fpu_res;
	hea_pkg::float_t   mant_f;
	logic [7:0]        ex_mag;
	logic              ex_neg;

	hea_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.done   (done),
		.result (fpu_res)
	);

	// Mantissa in [1,2) and the unbiased exponent of the probability.
	always_comb begin
		mant_f = (p_q & hea_pkg::MANT_MASK) | hea_pkg::FLOAT_ONE;
		ex_neg = p_q[30:23] < hea_pkg::EXP_BIAS;
		ex_mag = ex_neg ? hea_pkg::EXP_BIAS - p_q[30:23] : p_q[30:23] - hea_pkg::EXP_BIAS;
	end

	assign lane_last = (lane_q == hea_pkg::LANE_W'(hea_pkg::LANES - 1));

	// Sequencer: one float operation at a time per lane.
	always_comb begin
		state_d = state_q;
		req.op = hea_pkg::FPU_MUL;
		req.a = '0;
		req.b = '0;
		req.cvt_neg = 1'b0;
		req.cvt_mag = '0;
		op_state = 1'b0;
		lane_done = 1'b0;
		pop = 1'b0;
		emit = 1'b0;
		case (state_q)
			hea_pkg::BK_IDLE: if (head_valid) state_d = hea_pkg::BK_LANE;
			hea_pkg::BK_LANE: begin
				if (head.nonzero[lane_q]) state_d = hea_pkg::BK_CVT;
				else lane_done = 1'b1;
			end
			hea_pkg::BK_CVT: begin
				op_state = 1'b1;
				req.op = hea_pkg::FPU_CVT;
				req.cvt_mag = head.count[lane_q];
				if (done) state_d = hea_pkg::BK_SCALE;
			end
			hea_pkg::BK_SCALE: begin
				op_state = 1'b1;
				req.a = work_q;
				req.b = scale;
				if (done) state_d = hea_pkg::BK_HMUL;
			end
			hea_pkg::BK_HMUL: begin
				op_state = 1'b1;
				req.a = mant_f;
				req.b = work_q;
				if (done) state_d = hea_pkg::BK_HADD;
			end
			hea_pkg::BK_HADD: begin
				op_state = 1'b1;
				req.op = hea_pkg::FPU_ADD;
				req.a = hea_pkg::poly_coef(idx_q);
				req.b = work_q;
				if (done) state_d = (idx_q == '0) ? hea_pkg::BK_EXPCVT : hea_pkg::BK_HMUL;
			end
			hea_pkg::BK_EXPCVT: begin
				op_state = 1'b1;
				req.op = hea_pkg::FPU_CVT;
				req.cvt_neg = ex_neg;
				req.cvt_mag = {{(hea_pkg::COUNT_W - 8){1'b0}}, ex_mag};
				if (done) state_d = hea_pkg::BK_LOG;
			end
			hea_pkg::BK_LOG: begin
				op_state = 1'b1;
				req.op = hea_pkg::FPU_ADD;
				req.a = tmp_q;
				req.b = work_q;
				if (done) state_d = hea_pkg::BK_PROD;
			end
			hea_pkg::BK_PROD: begin
				op_state = 1'b1;
				req.a = work_q;
				req.b = p_q;
				if (done) state_d = hea_pkg::BK_ACC;
			end
			hea_pkg::BK_ACC: begin
				op_state = 1'b1;
				req.op = hea_pkg::FPU_ADD;
				req.a = sum_q[lane_q];
				req.b = work_q;
				if (done) lane_done = 1'b1;
			end
			hea_pkg::BK_EMIT: begin
				if (!res_valid_q || !result_stall) begin
					emit = 1'b1;
					pop = 1'b1;
					state_d = hea_pkg::BK_IDLE;
				end
			end
			default: state_d = hea_pkg::BK_IDLE;
		endcase
		if (lane_done) begin
			if (!lane_last) begin
				state_d = hea_pkg::BK_LANE;
			end else if (head.last) begin
				state_d = hea_pkg::BK_EMIT;
			end else begin
				pop = 1'b1;
				state_d = hea_pkg::BK_IDLE;
			end
		end
		start = op_state & ~busy_q;
	end

	// Control state, lane sums and the output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hea_pkg::BK_IDLE;
			lane_q <= '0;
			busy_q <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < hea_pkg::LANES; i++) sum_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (start) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (lane_done) lane_q <= lane_last ? '0 : lane_q + hea_pkg::LANE_W'(1);
			if (state_q == hea_pkg::BK_ACC && done) sum_q[lane_q] <= fpu_res;
			if (emit) begin
				for (int i = 0; i < hea_pkg::LANES; i++) sum_q[i] <= '0;
			end
			if (emit) res_valid_q <= 1'b1;
			else if (!result_stall) res_valid_q <= 1'b0;
		end
	end

	// Working values of the current lane and the result transfer data.
	always_ff @(posedge clk) begin
		case (state_q)
			hea_pkg::BK_CVT: if (done) work_q <= fpu_res;
			hea_pkg::BK_SCALE: begin
				if (done) begin
					p_q <= fpu_res;
					work_q <= hea_pkg::poly_coef(hea_pkg::COEF_IDX_W'(hea_pkg::POLY_DEGREE));
					idx_q <= hea_pkg::COEF_IDX_W'(hea_pkg::POLY_DEGREE - 1);
				end
			end
			hea_pkg::BK_HMUL: if (done) work_q <= fpu_res;
			hea_pkg::BK_HADD: begin
				if (done) begin
					work_q <= fpu_res;
					idx_q <= idx_q - hea_pkg::COEF_IDX_W'(1);
				end
			end
			hea_pkg::BK_EXPCVT: if (done) tmp_q <= fpu_res;
			hea_pkg::BK_LOG: if (done) work_q <= fpu_res;
			hea_pkg::BK_PROD: if (done) work_q <= fpu_res;
			default: begin
			end
		endcase
		if (emit) begin
			for (int i = 0; i < hea_pkg::LANES; i++) begin
				res_q[i] <= sum_q[i] ^ {negate, {(hea_pkg::FLOAT_W - 1){1'b0}}};
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/histogram_entropy_accumulator.sv
// Histogram entropy accumulator. Each accepted word carries eight bin counts; every nonzero
// count c becomes p = float(c) * (1/total_pixels) in IEEE single precision, log2 p is taken
// as the exponent of p plus a degree-6 polynomial on its mantissa, and p * log2 p is added
// to that lane's float sum. A word with last_word set produces one result transfer with the
// eight sums (sign-flipped when negate_sum is 1) and clears the sums. All float work goes
// through one three-stage multiply/add/convert unit, eighteen operations per nonzero lane
// and none for a zero lane. A two-entry queue takes words while the lanes are processed
// and while a result waits. Writing total_pixels starts a bit-serial reciprocal;
// cfg_ready is low and item_stall is high until it completes.
`default_nettype none

module histogram_entropy_accumulator (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [0:0]  cfg_index,
	input  wire [24:0] cfg_data,
	input  wire        item_valid,
	output logic       item_stall,
	input  wire [24:0] count_lane0,
	input  wire [24:0] count_lane1,
	input  wire [24:0] count_lane2,
	input  wire [24:0] count_lane3,
	input  wire [24:0] count_lane4,
	input  wire [24:0] count_lane5,
	input  wire [24:0] count_lane6,
	input  wire [24:0] count_lane7,
	input  wire        last_word,
	output logic       result_valid,
	input  wire        result_stall,
	output logic [31:0] entropy_lane0,
	output logic [31:0] entropy_lane1,
	output logic [31:0] entropy_lane2,
	output logic [31:0] entropy_lane3,
	output logic [31:0] entropy_lane4,
	output logic [31:0] entropy_lane5,
	output logic [31:0] entropy_lane6,
	output logic [31:0] entropy_lane7
);

	logic [hea_pkg::LANES-1:0][hea_pkg::COUNT_W-1:0] counts;
	logic [hea_pkg::LANES-1:0][hea_pkg::FLOAT_W-1:0] sums;
	hea_pkg::word_t         head;
	hea_pkg::queue_status_t q_status;
	hea_pkg::float_t        scale;
	logic                   pop, recip_busy, cfg_write, negate_q;

	assign counts[0] = count_lane0;
	assign counts[1] = count_lane1;
	assign counts[2] = count_lane2;
	assign counts[3] = count_lane3;
	assign counts[4] = count_lane4;
	assign counts[5] = count_lane5;
	assign counts[6] = count_lane6;
	assign counts[7] = count_lane7;

	// Configuration writes; the scale register lives in the reciprocal unit.
	assign cfg_ready = ~recip_busy;
	assign cfg_write = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			negate_q <= 1'b1;
		end else if (cfg_write && cfg_index == hea_pkg::CFG_NEGATE_SUM) begin
			negate_q <= cfg_data[0];
		end
	end

	hea_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_write && cfg_index == hea_pkg::CFG_TOTAL_PIXELS),
		.total  (cfg_data),
		.busy   (recip_busy),
		.scale  (scale)
	);

	hea_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.counts     (counts),
		.last       (last_word),
		.hold       (recip_busy),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	hea_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (~q_status.empty),
		.pop          (pop),
		.scale        (scale),
		.negate       (negate_q),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (sums)
	);

	assign entropy_lane0 = sums[0];
	assign entropy_lane1 = sums[1];
	assign entropy_lane2 = sums[2];
	assign entropy_lane3 = sums[3];
	assign entropy_lane4 = sums[4];
	assign entropy_lane5 = sums[5];
	assign entropy_lane6 = sums[6];
	assign entropy_lane7 = sums[7];

	// No word enters while the reciprocal is being computed.
	a_hold_items: assert property (@(posedge clk) disable iff (!arst_n)
		recip_busy |-> item_stall)
		else $error("word accepted during reciprocal computation");

	// A total_pixels write always starts the reciprocal unit.
	a_recip_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && cfg_index == hea_pkg::CFG_TOTAL_PIXELS) |=> recip_busy)
		else $error("reciprocal did not start after total write");

	// The queue is never both full and empty, and is never popped when empty.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty) && !(pop && q_status.empty))
		else $error("queue status inconsistent");

endmodule

`default_nettype wire

FILE: tb/histogram_entropy_accumulator_tb.sv
`timescale 1ns / 1ps

module histogram_entropy_accumulator_tb;
	import hea_pkg::*;

	localparam int DRAIN_CYCLES = 800;
	localparam logic [24:0] MAX_COUNT = 25'd16777216;

	// Mantissa polynomial for log2, lowest order first, as single bits.
	localparam float_t LOG_COEF [0:6] = '{
		32'hc041_e921, 32'h40c2_4b70, 32'hc0a8_bef7, 32'h404e_7cbf,
		32'hbf9e_6b92, 32'h3e89_0a2f, 32'hbccb_fe34
	};

	typedef logic [24:0] word_counts_t [0:7];
	typedef struct {
		float_t lane [0:7];
	} entropy_set_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [24:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic [24:0] count_lane [0:7];
	logic last_word;
	logic result_valid;
	logic result_stall;
	logic [31:0] entropy_lane [0:7];

	// Predictor state: lane sums, probability scale and output sign mode.
	float_t lane_acc [0:7];
	float_t prob_scale;
	logic negate_mode;
	entropy_set_t entropy_due [$];

	int errors;
	int snd_idle_pct;
	int rcv_stall_pct;

	histogram_entropy_accumulator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.count_lane0(count_lane[0]),
		.count_lane1(count_lane[1]),
		.count_lane2(count_lane[2]),
		.count_lane3(count_lane[3]),
		.count_lane4(count_lane[4]),
		.count_lane5(count_lane[5]),
		.count_lane6(count_lane[6]),
		.count_lane7(count_lane[7]),
		.last_word(last_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.entropy_lane0(entropy_lane[0]),
		.entropy_lane1(entropy_lane[1]),
		.entropy_lane2(entropy_lane[2]),
		.entropy_lane3(entropy_lane[3]),
		.entropy_lane4(entropy_lane[4]),
		.entropy_lane5(entropy_lane[5]),
		.entropy_lane6(entropy_lane[6]),
		.entropy_lane7(entropy_lane[7])
	);

	always #10 clk = ~clk;

	// Round a double to single bits, nearest-even. Operands here are never subnormal.
	function automatic float_t to_single(input real r);
		logic [63:0] b;
		logic [52:0] mt;
		logic [24:0] m;
		logic [28:0] rest;
		int se;
		b = $realtobits(r);
		if (b[62:52] == 11'd0)
			return {b[63], 31'b0};
		mt = {1'b1, b[51:0]};
		m = {1'b0, mt[52:29]};
		rest = mt[28:0];
		se = int'(b[62:52]) - 1023 + 127;
		if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && m[0]))
			m = m + 25'd1;
		if (m[24]) begin
			m = m >> 1;
			se = se + 1;
		end
		return {b[63], se[7:0], m[22:0]};
	endfunction

	function automatic real to_real(input float_t f);
		logic [63:0] b;
		logic [10:0] e;
		if (f[30:23] == 8'd0) begin
			b = {f[31], 63'b0};
		end else begin
			e = 11'(int'(f[30:23]) - 127 + 1023);
			b = {f[31], e, f[22:0], 29'b0};
		end
		return $bitstoreal(b);
	endfunction

	// A single product or sum is exact or safely double-rounded through a double.
	function automatic float_t fmul(input float_t a, input float_t b);
		return to_single(to_real(a) * to_real(b));
	endfunction

	function automatic float_t fadd(input float_t a, input float_t b);
		return to_single(to_real(a) + to_real(b));
	endfunction

	// Exponent field plus the Horner polynomial on the mantissa.
	function automatic float_t approx_log2(input float_t p);
		int ex;
		float_t m;
		float_t y;
		ex = int'(p[30:23]) - 127;
		m = (p & MANT_MASK) | FLOAT_ONE;
		y = LOG_COEF[6];
		for (int i = 5; i >= 0; i--)
			y = fadd(LOG_COEF[i], fmul(m, y));
		return fadd(to_single(real'(ex)), y);
	endfunction

	// Fold one accepted word into the lane sums; a last word queues the emitted set.
	task automatic accumulate_word(input word_counts_t c, input logic lst);
		float_t p;
		entropy_set_t e;
		for (int i = 0; i < 8; i++) begin
			if (c[i] != 25'd0) begin
				p = fmul(to_single(real'(c[i])), prob_scale);
				lane_acc[i] = fadd(lane_acc[i], fmul(approx_log2(p), p));
			end
		end
		if (lst) begin
			for (int i = 0; i < 8; i++) begin
				e.lane[i] = lane_acc[i] ^ {negate_mode, 31'b0};
				lane_acc[i] = 32'h0;
			end
			entropy_due.push_back(e);
		end
	endtask

	// Drive one word, optionally after an idle gap, and hold it until the transfer.
	task automatic send_word(input word_counts_t c, input logic lst);
		bit acc;
		if ($urandom_range(99) < snd_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		for (int i = 0; i < 8; i++)
			count_lane[i] <= c[i];
		last_word <= lst;
		item_valid <= 1'b1;
		do begin
			@(negedge clk);
			acc = !item_stall;
			@(posedge clk);
		end while (!acc);
		accumulate_word(c, lst);
	endtask

	// Block until every queued result has been checked, then let the pipeline settle.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (entropy_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [24:0] data);
		bit acc;
		wait_idle();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		if (idx == CFG_TOTAL_PIXELS)
			prob_scale = to_single(1.0 / real'(data == 25'd0 ? 25'd1 : data));
		else
			negate_mode = data[0];
	endtask

	function automatic logic [24:0] rand_count();
		case ($urandom_range(9))
			0, 1: return 25'd0;
			2: return 25'($urandom_range(16, 1));
			3: return MAX_COUNT;
			4: return 25'($urandom_range(16777215, 8388608));
			default: return 25'($urandom_range(16777216, 0));
		endcase
	endfunction

	function automatic word_counts_t fill_counts(input logic [24:0] v);
		word_counts_t c;
		for (int i = 0; i < 8; i++)
			c[i] = v;
		return c;
	endfunction

	// Result checker: a transfer is seen at the negedge before the edge that takes it.
	always @(negedge clk) begin
		entropy_set_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (entropy_due.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = entropy_due.pop_front();
				for (int i = 0; i < 8; i++) begin
					if (entropy_lane[i] !== e.lane[i]) begin
						$error("entropy_lane%0d expected %h actual %h", i, e.lane[i],
							entropy_lane[i]);
						errors++;
					end
				end
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < rcv_stall_pct);

	// Reset values: scale one, negated output; includes all-zero and oversized counts.
	task automatic test_reset_defaults();
		word_counts_t c;
		send_word(fill_counts(25'd0), 1'b1);
		send_word(fill_counts(25'd1), 1'b1);
		send_word(fill_counts(MAX_COUNT), 1'b0);
		c = '{25'd0, 25'd1, 25'd2, 25'd3, 25'd0, 25'd100, MAX_COUNT, 25'd7};
		send_word(c, 1'b1);
	endtask

	// Register extremes, both sign modes, and probabilities near one.
	task automatic test_register_extremes();
		word_counts_t c;
		write_reg(CFG_TOTAL_PIXELS, MAX_COUNT);
		write_reg(CFG_NEGATE_SUM, 1'b0);
		send_word(fill_counts(MAX_COUNT), 1'b1);
		send_word(fill_counts(25'd1), 1'b0);
		send_word(fill_counts(25'h0aa_aaaa), 1'b0);
		send_word(fill_counts(25'h155_5555), 1'b1);
		send_word(fill_counts(25'd0), 1'b1);
		write_reg(CFG_TOTAL_PIXELS, 25'd1);
		send_word(fill_counts(25'd1), 1'b1);
		write_reg(CFG_NEGATE_SUM, 1'b1);
		write_reg(CFG_TOTAL_PIXELS, 25'd3);
		c = '{25'd1, 25'd2, 25'd3, 25'd4, 25'd0, 25'd5, 25'd6, 25'd9};
		send_word(c, 1'b1);
	endtask

	// Random histograms in phases with different idle and stall rates.
	task automatic test_random_phases();
		word_counts_t c;
		int pct [0:3][0:1];
		pct = '{'{0, 0}, '{45, 0}, '{0, 45}, '{31, 31}};
		for (int ph = 0; ph < 4; ph++) begin
			snd_idle_pct = pct[ph][0];
			rcv_stall_pct = pct[ph][1];
			if (ph == 3)
				write_reg(CFG_TOTAL_PIXELS, MAX_COUNT);
			else
				write_reg(CFG_TOTAL_PIXELS, 25'($urandom_range(16777216, 1)));
			write_reg(CFG_NEGATE_SUM, 1'($urandom_range(1)));
			for (int n = 0; n < 108; n++) begin
				for (int i = 0; i < 8; i++)
					c[i] = rand_count();
				send_word(c, ($urandom_range(3) == 0) || n == 107);
				// Let the result queue drain completely once mid-phase.
				if (n == 50)
					wait_idle();
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		last_word = 1'b0;
		result_stall = 1'b0;
		for (int i = 0; i < 8; i++) begin
			count_lane[i] = '0;
			lane_acc[i] = 32'h0;
		end
		prob_scale = FLOAT_ONE;
		negate_mode = 1'b1;
		errors = 0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_phases();
		wait_idle();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#60_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
